### rtl/crm_pkg.sv
package crm_pkg;

   localparam int DEF_CAPACITY    = 256;
   localparam int DEF_BUCKETS     = 512;
   localparam int DEF_HANDLE_BITS = 16;
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [31:0] HASH_SEED = 32'd61;
   localparam logic [31:0] HASH_MUL  = 32'h27d4eb2d;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_ERASE  = 2'd1,
      OP_GET    = 2'd2,
      OP_RSVD   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_HEAD,
      BK_WALK,
      BK_CMP,
      BK_ACT,
      BK_ALLOC
   } back_state_type;

   // first half of the mix, before the multiply
   function automatic logic [31:0] hash_pre(input logic [31:0] k);
      logic [31:0] h;
      h = (k ^ HASH_SEED) ^ (k >> 16);
      h = h + (h << 3);
      h = h ^ (h >> 4);
      return h;
   endfunction

   function automatic logic [31:0] hash_post(input logic [31:0] h);
      return h ^ (h >> 15);
   endfunction

endpackage

### rtl/crm_queue.sv
module crm_queue
   import crm_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? ((wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? ((rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= wdata;
      end
   end

endmodule

### rtl/crm_front.sv
module crm_front
   import crm_pkg::*;
#(
   parameter int BKT_W       = $clog2(DEF_BUCKETS),
   parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [1:0]             req_op,
   input  logic [31:0]            req_key,
   input  logic [HANDLE_BITS-1:0] req_handle,
   output logic                   q_push,
   input  logic                   q_full,
   output logic [1:0]             q_op,
   output logic [31:0]            q_key,
   output logic [HANDLE_BITS-1:0] q_handle,
   output logic [BKT_W-1:0]       q_bucket
);

   logic                   s1_v_ff, s2_v_ff;
   logic [1:0]             s1_op_ff, s2_op_ff;
   logic [31:0]            s1_key_ff, s2_key_ff;
   logic [HANDLE_BITS-1:0] s1_hnd_ff, s2_hnd_ff;
   logic [31:0]            s1_h_ff, s2_h_ff;
   logic [31:0]            h_fin;
   logic                   adv;

   // whole pipe moves together; only the tail can block
   assign adv      = !(s2_v_ff && q_full);
   assign req_full = !adv;
   assign q_push   = s2_v_ff && !q_full;
   assign h_fin    = hash_post(s2_h_ff);
   assign q_op     = s2_op_ff;
   assign q_key    = s2_key_ff;
   assign q_handle = s2_hnd_ff;
   assign q_bucket = h_fin[BKT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_push;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff  <= req_op;
         s1_key_ff <= req_key;
         s1_hnd_ff <= req_handle;
         s1_h_ff   <= hash_pre(req_key);
         s2_op_ff  <= s1_op_ff;
         s2_key_ff <= s1_key_ff;
         s2_hnd_ff <= s1_hnd_ff;
         s2_h_ff   <= s1_h_ff * HASH_MUL;
      end
   end

endmodule

### rtl/crm_back.sv
module crm_back
   import crm_pkg::*;
#(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int BUCKETS     = DEF_BUCKETS,
   parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   output logic                          q_pop,
   input  logic [1:0]                    q_op,
   input  logic [31:0]                   q_key,
   input  logic [HANDLE_BITS-1:0]        q_handle,
   input  logic [$clog2(BUCKETS)-1:0]    q_bucket,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [1:0]                    rsp_status,
   output logic [HANDLE_BITS-1:0]        rsp_found_handle
);

   localparam int BKT_W = $clog2(BUCKETS);
   localparam int ENT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int IDX_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(CAPACITY);

   // storage
   logic [IDX_W-1:0]       heads_mem [BUCKETS];
   logic [31:0]            key_mem   [CAPACITY];
   logic [HANDLE_BITS-1:0] hnd_mem   [CAPACITY];
   logic [IDX_W-1:0]       link_mem  [CAPACITY];
   logic [ENT_W-1:0]       free_mem  [CAPACITY];

   logic [IDX_W-1:0]       heads_rd, link_rd;
   logic [31:0]            key_rd;
   logic [HANDLE_BITS-1:0] hnd_rd;
   logic [ENT_W-1:0]       free_rd;

   back_state_type state_ff, state_in;

   logic [BKT_W-1:0]       clr_ff;
   op_type                 op_ff;
   logic [31:0]            key_ff;
   logic [HANDLE_BITS-1:0] hnd_ff;
   logic [BKT_W-1:0]       bkt_ff;
   logic [IDX_W-1:0]       cur_ff, prev_ff, head_ff, nxt_ff;
   logic [HANDLE_BITS-1:0] fhnd_ff;
   logic                   hit_ff;
   logic [IDX_W-1:0]       count_ff, fdepth_ff, fresh_ff;
   logic                   out_v_ff;
   status_type             out_status_ff;
   logic [HANDLE_BITS-1:0] out_handle_ff;

   logic                   out_free;
   logic                   key_match;
   logic [ENT_W-1:0]       alloc_e;
   logic [ENT_W-1:0]       fdepth_top;

   // write strobes and result load
   logic                   heads_we, ent_we, link_we, free_we;
   logic [BKT_W-1:0]       heads_wa;
   logic [IDX_W-1:0]       heads_wd, link_wd;
   logic [ENT_W-1:0]       link_wa;
   logic                   res_load;
   status_type             res_status;
   logic [HANDLE_BITS-1:0] res_handle;
   logic                   do_alloc, do_unlink;

   assign out_free   = !out_v_ff || rsp_pop;
   assign key_match  = (key_rd == key_ff);
   assign alloc_e    = (fdepth_ff != '0) ? free_rd : fresh_ff[ENT_W-1:0];
   assign fdepth_top = ENT_W'(fdepth_ff - 1'b1);

   assign rsp_empty        = !out_v_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_found_handle = out_handle_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: if (clr_ff == BKT_W'(BUCKETS - 1)) state_in = BK_IDLE;
         BK_IDLE:  if (!q_empty && out_free) state_in = BK_HEAD;
         BK_HEAD:  state_in = BK_WALK;
         BK_WALK:  state_in = (cur_ff == NULL_IDX) ? BK_ACT : BK_CMP;
         BK_CMP:   state_in = key_match ? BK_ACT : BK_WALK;
         BK_ACT: begin
            if (op_ff == OP_INSERT && !hit_ff && count_ff != IDX_W'(CAPACITY)) begin
               state_in = BK_ALLOC;
            end else begin
               state_in = BK_IDLE;
            end
         end
         BK_ALLOC: state_in = BK_IDLE;
         default:  state_in = BK_CLEAR;
      endcase
   end

   // strobes
   always_comb begin
      q_pop      = (state_ff == BK_IDLE) && !q_empty && out_free;
      do_alloc   = (state_ff == BK_ALLOC);
      do_unlink  = (state_ff == BK_ACT) && (op_ff == OP_ERASE) && hit_ff;
      heads_we   = 1'b0;
      heads_wa   = bkt_ff;
      heads_wd   = nxt_ff;
      ent_we     = do_alloc;
      link_we    = 1'b0;
      link_wa    = alloc_e;
      link_wd    = head_ff;
      free_we    = do_unlink;
      res_load   = 1'b0;
      res_status = ST_OK;
      res_handle = '0;
      if (state_ff == BK_CLEAR) begin
         heads_we = 1'b1;
         heads_wa = clr_ff;
         heads_wd = NULL_IDX;
      end
      if (do_alloc) begin
         heads_we = 1'b1;
         heads_wd = IDX_W'(alloc_e);
         link_we  = 1'b1;
         res_load = 1'b1;
      end
      if (do_unlink) begin
         if (prev_ff == NULL_IDX) begin
            heads_we = 1'b1;
         end else begin
            link_we = 1'b1;
            link_wa = prev_ff[ENT_W-1:0];
            link_wd = nxt_ff;
         end
      end
      if (state_ff == BK_ACT) begin
         case (op_ff)
            OP_INSERT: begin
               if (hit_ff) begin
                  res_load   = 1'b1;
                  res_status = ST_DUPLICATE;
               end else if (count_ff == IDX_W'(CAPACITY)) begin
                  res_load   = 1'b1;
                  res_status = ST_FULL;
               end
            end
            OP_ERASE: begin
               res_load   = 1'b1;
               res_status = hit_ff ? ST_OK : ST_NOT_FOUND;
            end
            default: begin
               res_load   = 1'b1;
               res_status = hit_ff ? ST_OK : ST_NOT_FOUND;
               res_handle = hit_ff ? fhnd_ff : '0;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_CLEAR;
         clr_ff    <= '0;
         count_ff  <= '0;
         fdepth_ff <= '0;
         fresh_ff  <= '0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (do_alloc) begin
            count_ff <= count_ff + 1'b1;
            if (fdepth_ff != '0) fdepth_ff <= fdepth_ff - 1'b1;
            else                 fresh_ff  <= fresh_ff + 1'b1;
         end
         if (do_unlink) begin
            count_ff  <= count_ff - 1'b1;
            fdepth_ff <= fdepth_ff + 1'b1;
         end
         if (res_load)     out_v_ff <= 1'b1;
         else if (rsp_pop) out_v_ff <= 1'b0;
      end
   end

   // transaction context and walk registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff  <= op_type'(q_op);
         key_ff <= q_key;
         hnd_ff <= q_handle;
         bkt_ff <= q_bucket;
      end
      if (state_ff == BK_HEAD) begin
         head_ff <= heads_rd;
         cur_ff  <= heads_rd;
         prev_ff <= NULL_IDX;
         hit_ff  <= 1'b0;
      end
      if (state_ff == BK_CMP) begin
         if (key_match) begin
            hit_ff  <= 1'b1;
            nxt_ff  <= link_rd;
            fhnd_ff <= hnd_rd;
         end else begin
            prev_ff <= cur_ff;
            cur_ff  <= link_rd;
         end
      end
      if (res_load) begin
         out_status_ff <= res_status;
         out_handle_ff <= res_handle;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      heads_rd <= heads_mem[q_bucket];
      if (heads_we) heads_mem[heads_wa] <= heads_wd;
   end

   always_ff @(posedge clock) begin
      key_rd  <= key_mem[cur_ff[ENT_W-1:0]];
      hnd_rd  <= hnd_mem[cur_ff[ENT_W-1:0]];
      link_rd <= link_mem[cur_ff[ENT_W-1:0]];
      if (ent_we) begin
         key_mem[alloc_e] <= key_ff;
         hnd_mem[alloc_e] <= hnd_ff;
      end
      if (link_we) link_mem[link_wa] <= link_wd;
   end

   always_ff @(posedge clock) begin
      free_rd <= free_mem[fdepth_top];
      if (free_we) free_mem[fdepth_ff[ENT_W-1:0]] <= cur_ff[ENT_W-1:0];
   end

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IDX_W'(CAPACITY))
      else $error("entry count above capacity");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (!out_v_ff || rsp_pop))
      else $error("result register overwritten");

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CLEAR) |-> !q_pop)
      else $error("queue popped during bucket clear");

   a_alloc_room: assert property (@(posedge clock) disable iff (reset)
      do_alloc |-> (fdepth_ff != '0 || fresh_ff < IDX_W'(CAPACITY)))
      else $error("allocation with no free entry");

endmodule

### rtl/chained_hash_map_engine.sv
// Chained hash map: 32-bit key to handle, CAPACITY entries over BUCKETS chains
// (both powers of two). Each request transaction is an insert, erase or get and
// yields exactly one response transaction (status, found_handle) in order.
// A front pipeline hashes the key (Wang shift-multiply, two register stages
// around the 32x32 multiply) into a four-entry queue; the back sequencer walks
// the bucket chain in one-read one-write memories with registered reads. Per
// request the back end steps through pop, head read, walk and act, plus walk
// and compare for each chain entry passed without a match, compare for a
// matching entry and allocate for a successful insert; a request starts only
// once the previous response has been taken, and chain walking sets the rate.
// After reset the back end nulls the bucket heads; requests queue meanwhile.
module chained_hash_map_engine
   import crm_pkg::*;
#(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int BUCKETS     = DEF_BUCKETS,
   parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   // request side
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [1:0]             req_op,
   input  logic [31:0]            req_key,
   input  logic [HANDLE_BITS-1:0] req_handle,
   // response side
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [1:0]             rsp_status,
   output logic [HANDLE_BITS-1:0] rsp_found_handle
);

   localparam int BKT_W = $clog2(BUCKETS);
   localparam int Q_W   = 2 + 32 + HANDLE_BITS + BKT_W;

   logic                   f_push, f_full, b_pop, b_empty;
   logic [1:0]             f_op, b_op;
   logic [31:0]            f_key, b_key;
   logic [HANDLE_BITS-1:0] f_hnd, b_hnd;
   logic [BKT_W-1:0]       f_bkt, b_bkt;
   logic [Q_W-1:0]         q_rdata;

   // hash front end
   crm_front #(.BKT_W(BKT_W), .HANDLE_BITS(HANDLE_BITS)) u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_op(req_op), .req_key(req_key), .req_handle(req_handle),
      .q_push(f_push), .q_full(f_full),
      .q_op(f_op), .q_key(f_key), .q_handle(f_hnd), .q_bucket(f_bkt)
   );

   // decoupling queue between hashing and table work
   crm_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push(f_push), .full(f_full), .wdata({f_op, f_key, f_hnd, f_bkt}),
      .pop(b_pop), .empty(b_empty), .rdata(q_rdata)
   );

   assign {b_op, b_key, b_hnd, b_bkt} = q_rdata;

   // table sequencer and response register
   crm_back #(.CAPACITY(CAPACITY), .BUCKETS(BUCKETS), .HANDLE_BITS(HANDLE_BITS)) u_back (
      .clock(clock), .reset(reset),
      .q_empty(b_empty), .q_pop(b_pop),
      .q_op(b_op), .q_key(b_key), .q_handle(b_hnd), .q_bucket(b_bkt),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_status(rsp_status), .rsp_found_handle(rsp_found_handle)
   );

endmodule
